// ===== src/rds_pkg.sv =====
package rds_pkg;

	localparam int CELLS = 64;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = $clog2(CELLS + 2);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int VW    = 48;
	localparam int LW    = 52;
	localparam int NB    = 53;
	localparam int DW    = $clog2(CELLS + 255);
	localparam int SUMW  = NB + 2;
	localparam int IW    = 6;
	localparam int ALW   = 32;
	localparam int ROW   = 8;
	localparam int SIW   = 40;
	localparam int CFW   = 40;
	localparam int CIW   = 2;

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	localparam logic [CIW-1:0] CFG_ALPHA = 2'd0;
	localparam logic [CIW-1:0] CFG_RO    = 2'd1;
	localparam logic [CIW-1:0] CFG_SRC   = 2'd2;

	localparam logic [1:0] JOB_MID   = 2'd0;
	localparam logic [1:0] JOB_FIRST = 2'd1;
	localparam logic [1:0] JOB_LAST  = 2'd2;

	typedef struct packed {
		logic          shift;
		logic [AW-1:0] raddr;
		logic          job;
		logic [1:0]    jkind;
		logic [AW-1:0] jaddr;
	} stp_t;

	typedef struct packed {
		logic [AW-1:0]          addr;
		logic signed [NB-1:0]   a;
		logic signed [VW-1:0]   ctr;
		logic                   neg;
	} dpl_t;

endpackage

// ===== src/rds_mem.sv =====
module rds_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [rds_pkg::AW-1:0]        waddr,
	input  logic signed [rds_pkg::VW-1:0] wdata,
	input  logic                          re,
	input  logic [rds_pkg::AW-1:0]        raddr,
	output logic signed [rds_pkg::VW-1:0] rdata
);

	logic signed [rds_pkg::VW-1:0] mem [rds_pkg::CELLS];
	logic [rds_pkg::CELLS-1:0]     vld_q;
	logic signed [rds_pkg::VW-1:0] rd_q;
	logic                          rvld_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (re)
				rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rd_q : '0;

endmodule

// ===== src/rds_stencil.sv =====
module rds_stencil (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rds_pkg::stp_t                 stp_s1,
	input  logic signed [rds_pkg::VW-1:0] rdata,
	input  logic [rds_pkg::ALW-1:0]       alpha,
	input  logic [rds_pkg::ROW-1:0]       ro,
	input  logic [rds_pkg::SIW-1:0]       src_inc,
	output logic                          src_sat,
	output logic                          dvld,
	output logic [rds_pkg::NB-1:0]        dnum,
	output logic [rds_pkg::DW-1:0]        dden,
	output rds_pkg::dpl_t                 dpl
);

	localparam int LW  = rds_pkg::LW;
	localparam int VW  = rds_pkg::VW;
	localparam int NB  = rds_pkg::NB;
	localparam int AW  = rds_pkg::AW;
	localparam int DW  = rds_pkg::DW;
	localparam int ROW = rds_pkg::ROW;

	logic signed [VW+1:0] csum;
	logic signed [VW-1:0] cval;
	logic signed [VW-1:0] win_q [4];
	logic                 job_s2;
	logic [1:0]           jkind_s2;
	logic [AW-1:0]        jaddr_s2;

	logic signed [LW-1:0] x0, x1, x2, x3, lap, der;
	logic signed [VW-1:0] ctr;
	logic                 vld_s3;
	logic signed [LW-1:0] lap_s3, der_s3;
	logic signed [VW-1:0] ctr_s3;
	logic [AW-1:0]        addr_s3;

	logic [LW-1:0]        magl, magd;
	logic                 vld_s4;
	logic [63:0]          plol_s4, plod_s4;
	logic [LW-1:0]        phil_s4, phid_s4;
	logic                 negl_s4, negd_s4;
	logic signed [VW-1:0] ctr_s4;
	logic [AW-1:0]        addr_s4;

	logic [NB-1:0]        rl, rd;
	logic [ROW-1:0]       ro_eff;
	logic [DW-1:0]        den;

	// source amount lands on shells 0 and 1 as they stream in
	always_comb begin
		csum = (VW+2)'(rdata);
		if (stp_s1.raddr < AW'(2))
			csum = csum + (VW+2)'(signed'({1'b0, src_inc}));
		src_sat = 1'b0;
		cval    = csum[VW-1:0];
		if (csum > (VW+2)'(rds_pkg::VMAX)) begin
			cval    = rds_pkg::VMAX;
			src_sat = stp_s1.shift;
		end else if (csum < (VW+2)'(rds_pkg::VMIN)) begin
			cval    = rds_pkg::VMIN;
			src_sat = stp_s1.shift;
		end
	end

	always_ff @(posedge clk) begin
		if (stp_s1.shift) begin
			win_q[0] <= cval;
			win_q[1] <= win_q[0];
			win_q[2] <= win_q[1];
			win_q[3] <= win_q[2];
		end
		jkind_s2 <= stp_s1.jkind;
		jaddr_s2 <= stp_s1.jaddr;
	end

	// window: win_q[0] newest
	always_comb begin
		x0 = LW'(win_q[0]);
		x1 = LW'(win_q[1]);
		x2 = LW'(win_q[2]);
		x3 = LW'(win_q[3]);
		unique case (jkind_s2)
			rds_pkg::JOB_FIRST: begin
				lap = -x0 + (x1 <<< 2) - (x2 <<< 2) - x2 + (x3 <<< 1);
				der = -x1 + (x2 <<< 2) - (x3 <<< 1) - x3;
				ctr = win_q[3];
			end
			rds_pkg::JOB_LAST: begin
				lap = -x3 + (x2 <<< 2) - (x1 <<< 2) - x1 + (x0 <<< 1);
				der = (x0 <<< 1) + x0 - (x1 <<< 2) + x2;
				ctr = win_q[0];
			end
			rds_pkg::JOB_MID: begin
				lap = x0 - (x1 <<< 1) + x2;
				der = x0 - x2;
				ctr = win_q[1];
			end
			default: begin
				lap = '0;
				der = '0;
				ctr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		lap_s3  <= lap;
		der_s3  <= der;
		ctr_s3  <= ctr;
		addr_s3 <= jaddr_s2;
	end

	assign magl = lap_s3[LW-1] ? LW'(-lap_s3) : LW'(lap_s3);
	assign magd = der_s3[LW-1] ? LW'(-der_s3) : LW'(der_s3);

	always_ff @(posedge clk) begin
		plol_s4 <= {32'd0, magl[31:0]} * {32'd0, alpha};
		phil_s4 <= LW'(magl[LW-1:32]) * LW'(alpha);
		plod_s4 <= {32'd0, magd[31:0]} * {32'd0, alpha};
		phid_s4 <= LW'(magd[LW-1:32]) * LW'(alpha);
		negl_s4 <= lap_s3[LW-1];
		negd_s4 <= der_s3[LW-1];
		ctr_s4  <= ctr_s3;
		addr_s4 <= addr_s3;
	end

	// round half up on the dropped 32 fraction bits
	assign rl = NB'(phil_s4) + NB'(({1'b0, plol_s4} + 65'h80000000) >> 32);
	assign rd = NB'(phid_s4) + NB'(({1'b0, plod_s4} + 65'h80000000) >> 32);
	assign ro_eff = (ro == '0) ? ROW'(1) : ro;
	assign den = DW'(addr_s4) + DW'(ro_eff);

	always_ff @(posedge clk) begin
		dnum     <= rd + NB'(den >> 1);
		dden     <= den;
		dpl.addr <= addr_s4;
		dpl.a    <= negl_s4 ? -signed'(rl) : signed'(rl);
		dpl.ctr  <= ctr_s4;
		dpl.neg  <= negd_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			dvld   <= 1'b0;
		end else begin
			job_s2 <= stp_s1.job;
			vld_s3 <= job_s2;
			vld_s4 <= vld_s3;
			dvld   <= vld_s4;
		end
	end

endmodule

// ===== src/rds_div.sv =====
module rds_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ivld,
	input  logic [rds_pkg::NB-1:0] inum,
	input  logic [rds_pkg::DW-1:0] iden,
	input  rds_pkg::dpl_t          ipl,
	output logic                   ovld,
	output logic [rds_pkg::NB-1:0] oq,
	output rds_pkg::dpl_t          opl
);

	localparam int NB = rds_pkg::NB;
	localparam int DW = rds_pkg::DW;

	logic                vld_q [NB];
	logic [NB-1:0]       nq_q  [NB];
	logic [DW-1:0]       rem_q [NB];
	logic [DW-1:0]       den_q [NB];
	rds_pkg::dpl_t       pl_q  [NB];

	// one quotient bit per stage; numerator bits shift out as quotient bits shift in
	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic          v_in;
		logic [NB-1:0] nq_in;
		logic [DW-1:0] rem_in, den_in;
		rds_pkg::dpl_t pl_in;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in   = ivld;
			assign nq_in  = inum;
			assign rem_in = '0;
			assign den_in = iden;
			assign pl_in  = ipl;
		end else begin : g_next
			assign v_in   = vld_q[k-1];
			assign nq_in  = nq_q[k-1];
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign pl_in  = pl_q[k-1];
		end

		assign t  = {rem_in, nq_in[NB-1]};
		assign ge = t >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			nq_q[k]  <= {nq_in[NB-2:0], ge};
			rem_q[k] <= ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
			den_q[k] <= den_in;
			pl_q[k]  <= pl_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[k] <= 1'b0;
			else
				vld_q[k] <= v_in;
		end
	end

	assign ovld = vld_q[NB-1];
	assign oq   = nq_q[NB-1];
	assign opl  = pl_q[NB-1];

endmodule

// ===== src/radial_diffusion_step.sv =====
// Radial diffusion stepper over a profile of CELLS shells kept in one memory.
// Input stream s_*: tuser carries kind (1 = advance one time step, 0 = read),
// tdata carries the shell index. Each request yields one result on m_*:
// tdata is the shell value (signed Q32.16), tuser the saturation flag of the
// most recent time step.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 alpha, 1 radius offset, 2 source increment); the user is to do so only
// while the block is idle, and the block itself does not enforce it.
// A read request passes state FETCH, which reads the memory, and state
// LOAD, which registers the result. A step request streams the profile
// once, one shell read per cycle with a bubble after shell 3 and after the
// last shell, through the stencil, the alpha multipliers and a divider
// pipeline of NB stages. The next request can be accepted in the cycle
// after the result loads.
// One request is worked at a time; the next may be accepted while the
// previous result still waits in the output register.
// Reset clears the profile to zero, the flag, and loads the default
// register values. A stalled receiver holds the result in the output
// register; the block then finishes its work and waits to load.
module radial_diffusion_step (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [5:0] cell_index
	input  logic [0:0]               s_tuser,   // [0] kind
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [47:0]              m_tdata,   // [47:0] cell_value
	output logic [0:0]               m_tuser,   // [0] saturated
	input  logic                     cfg_we,
	input  logic [rds_pkg::CIW-1:0]  cfg_index,
	input  logic [rds_pkg::CFW-1:0]  cfg_data
);

	localparam int AW    = rds_pkg::AW;
	localparam int SW    = rds_pkg::SW;
	localparam int CW    = rds_pkg::CW;
	localparam int VW    = rds_pkg::VW;
	localparam int NB    = rds_pkg::NB;
	localparam int SUMW  = rds_pkg::SUMW;
	localparam int CELLS = rds_pkg::CELLS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;

	logic [2:0]                  state_q;
	logic [SW-1:0]               st_q;
	logic [CW-1:0]               wr_cnt_q;
	logic [rds_pkg::IW-1:0]      idx_q;
	logic                        sticky_q;
	logic [rds_pkg::ALW-1:0]     alpha_q;
	logic [rds_pkg::ROW-1:0]     ro_q;
	logic [rds_pkg::SIW-1:0]     src_q;
	logic                        m_tvalid_q;
	logic [VW-1:0]               m_tdata_q;
	logic                        m_tuser_q;

	rds_pkg::stp_t               stp, stp_s1;
	logic                        re;
	logic [AW-1:0]               raddr;
	logic signed [VW-1:0]        rdata;
	logic                        src_sat;
	logic                        dvld;
	logic [NB-1:0]               dnum;
	logic [rds_pkg::DW-1:0]      dden;
	rds_pkg::dpl_t               dpl;
	logic                        ovld;
	logic [NB-1:0]               oq;
	rds_pkg::dpl_t               opl;
	logic signed [NB-1:0]        cq;
	logic signed [SUMW-1:0]      sum;
	logic signed [VW-1:0]        wval;
	logic                        wsat;
	logic                        in_acc;
	logic                        load;
	logic                        in_range;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign load     = (state_q == ST_LOAD) && (!m_tvalid_q || m_tready);
	assign in_range = 32'(idx_q) < 32'(CELLS);

	// sweep schedule: reads 0..3, bubble, reads 4..CELLS-1, bubble
	always_comb begin
		stp = '0;
		stp.shift = 1'b1;
		if (st_q <= SW'(3))
			stp.raddr = AW'(st_q);
		else
			stp.raddr = AW'(st_q - SW'(1));
		priority if (st_q == SW'(CELLS + 1)) begin
			stp.shift = 1'b0;
			stp.job   = 1'b1;
			stp.jkind = rds_pkg::JOB_LAST;
			stp.jaddr = AW'(CELLS - 1);
		end else if (st_q == SW'(4)) begin
			stp.shift = 1'b0;
			stp.job   = 1'b1;
			stp.jkind = rds_pkg::JOB_MID;
			stp.jaddr = AW'(2);
		end else if (st_q == SW'(3)) begin
			stp.job   = 1'b1;
			stp.jkind = rds_pkg::JOB_FIRST;
			stp.jaddr = AW'(0);
		end else if (st_q == SW'(2)) begin
			stp.job   = 1'b1;
			stp.jkind = rds_pkg::JOB_MID;
			stp.jaddr = AW'(1);
		end else if (st_q >= SW'(5)) begin
			stp.job   = 1'b1;
			stp.jkind = rds_pkg::JOB_MID;
			stp.jaddr = AW'(st_q - SW'(2));
		end else begin
			stp.job   = 1'b0;
		end
		if (state_q != ST_SWEEP) begin
			stp.shift = 1'b0;
			stp.job   = 1'b0;
		end
	end

	assign re    = stp.shift || (state_q == ST_FETCH);
	assign raddr = (state_q == ST_FETCH) ? AW'(idx_q) : stp.raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stp_s1 <= '0;
		else
			stp_s1 <= stp;
	end

	rds_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ovld),
		.waddr  (opl.addr),
		.wdata  (wval),
		.re     (re),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	rds_stencil u_stencil (
		.clk     (clk),
		.arst_n  (arst_n),
		.stp_s1  (stp_s1),
		.rdata   (rdata),
		.alpha   (alpha_q),
		.ro      (ro_q),
		.src_inc (src_q),
		.src_sat (src_sat),
		.dvld    (dvld),
		.dnum    (dnum),
		.dden    (dden),
		.dpl     (dpl)
	);

	rds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ivld   (dvld),
		.inum   (dnum),
		.iden   (dden),
		.ipl    (dpl),
		.ovld   (ovld),
		.oq     (oq),
		.opl    (opl)
	);

	assign cq  = opl.neg ? -signed'(oq) : signed'(oq);
	assign sum = SUMW'(opl.ctr) + SUMW'(opl.a) + SUMW'(cq);

	always_comb begin
		wsat = 1'b0;
		wval = sum[VW-1:0];
		if (sum > SUMW'(rds_pkg::VMAX)) begin
			wval = rds_pkg::VMAX;
			wsat = 1'b1;
		end else if (sum < SUMW'(rds_pkg::VMIN)) begin
			wval = rds_pkg::VMIN;
			wsat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 32'd406948;
			ro_q    <= 8'd10;
			src_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rds_pkg::CFG_ALPHA: alpha_q <= cfg_data[rds_pkg::ALW-1:0];
				rds_pkg::CFG_RO:    ro_q    <= cfg_data[rds_pkg::ROW-1:0];
				rds_pkg::CFG_SRC:   src_q   <= cfg_data[rds_pkg::SIW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			st_q     <= '0;
			wr_cnt_q <= '0;
			sticky_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q     <= '0;
						wr_cnt_q <= '0;
						if (s_tuser[0]) begin
							sticky_q <= 1'b0;
							state_q  <= ST_SWEEP;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_SWEEP: begin
					st_q <= st_q + SW'(1);
					if (st_q == SW'(CELLS + 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (wr_cnt_q == CW'(CELLS))
						state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ovld)
				wr_cnt_q <= wr_cnt_q + CW'(1);
			if ((stp_s1.shift && src_sat) || (ovld && wsat))
				sticky_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			idx_q <= s_tdata[rds_pkg::IW-1:0];
		if (load) begin
			m_tdata_q <= in_range ? rdata : '0;
			m_tuser_q <= sticky_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

`ifndef SYNTH
	a_wr_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ovld |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("profile write outside a time step");

	a_wr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		wr_cnt_q <= CW'(CELLS))
		else $error("more shell writes than shells");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!dvld && !stp_s1.job))
		else $error("pipeline busy while idle");

	a_fetch_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_LOAD))
		else $error("fetch not followed by load");
`endif

endmodule
